### sv/gha_pkg.sv
// shared widths, operation codes and controller/datapath interface types
`default_nettype none

package gha_pkg;

    // request field widths
    localparam int FUNC_W    = 3;
    localparam int INDEX_W   = 10;
    localparam int GEN_IN_W  = 16;
    localparam int BIT_W     = 6;
    localparam int MASK_W    = 64;

    // stream payload widths, padded to whole bytes
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 96;
    localparam int M_PAD_W   = M_TDATA_W - (INDEX_W + GEN_IN_W + MASK_W);

    typedef enum logic [FUNC_W-1:0] {
        F_CREATE   = 3'd0,
        F_FREE     = 3'd1,
        F_SET_BIT  = 3'd2,
        F_CLR_BIT  = 3'd3,
        F_SET_MASK = 3'd4,
        F_CLR_MASK = 3'd5,
        F_TEST_BIT = 3'd6,
        F_READ_SIG = 3'd7
    } t_func;

    typedef struct packed {
        logic clr_step;
        logic capture;
        logic exec;
    } t_cmd;

    typedef struct packed {
        logic clr_last;
    } t_status;

endpackage

`default_nettype wire

### sv/gha_ctrl.sv
// sequencing fsm: clearing pass, request capture, execute and output handshake
`default_nettype none

module gha_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    input  wire gha_pkg::t_status i_status,
    output gha_pkg::t_cmd      o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   accept;

    // a request may enter while the result is being taken in the same cycle
    assign o_s_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_tready);
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_out_valid;

    always_comb begin
        o_cmd.clr_step = (r_state == S_CLEAR);
        o_cmd.capture  = accept;
        o_cmd.exec     = (r_state == S_EXEC);
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (i_status.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_EXEC) begin
                r_out_valid <= 1'b1;
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### sv/gha_datapath.sv
// slot table, free list fifo, handle checks and signature update logic
`default_nettype none

module gha_datapath #(
    parameter int MAX_SLOTS       = 1024,
    parameter int SIGNATURE_BITS  = 64,
    parameter int GENERATION_BITS = 16
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire gha_pkg::t_cmd                   i_cmd,
    output gha_pkg::t_status                     o_status,
    input  wire gha_pkg::t_func                  i_func,
    input  wire logic [gha_pkg::INDEX_W-1:0]     i_slot_index,
    input  wire logic [gha_pkg::GEN_IN_W-1:0]    i_generation_in,
    input  wire logic [gha_pkg::BIT_W-1:0]       i_bit_index,
    input  wire logic [gha_pkg::MASK_W-1:0]      i_bit_mask,
    output logic                                 o_ok,
    output logic [gha_pkg::INDEX_W-1:0]          o_new_index,
    output logic [gha_pkg::GEN_IN_W-1:0]         o_new_generation,
    output logic [gha_pkg::MASK_W-1:0]           o_signature_out
);

    localparam int IDX_W  = gha_pkg::INDEX_W;
    localparam int GIN_W  = gha_pkg::GEN_IN_W;
    localparam int MSK_W  = gha_pkg::MASK_W;
    localparam int SIG_W  = SIGNATURE_BITS;
    localparam int GEN_W  = GENERATION_BITS;
    localparam int SLOT_W = $clog2(MAX_SLOTS);
    localparam int CNT_W  = $clog2(MAX_SLOTS + 1);
    localparam int ENT_W  = GEN_W + SIG_W;
    localparam int FIFO_W = SLOT_W + GEN_W;

    localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(MAX_SLOTS - 1);
    localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(MAX_SLOTS);
    localparam logic [GEN_W-1:0]  GEN_ONE    = GEN_W'(1);

    // slot entry holds {generation, signature}; fifo entry holds {slot, generation}
    logic [ENT_W-1:0]  r_slot_mem [MAX_SLOTS];
    logic [FIFO_W-1:0] r_fifo_mem [MAX_SLOTS];
    logic [ENT_W-1:0]  r_slot_rd;
    logic [FIFO_W-1:0] r_fifo_rd;

    gha_pkg::t_func    r_func;
    logic [IDX_W-1:0]  r_slot;
    logic [GIN_W-1:0]  r_gen;
    logic [gha_pkg::BIT_W-1:0] r_bit;
    logic [MSK_W-1:0]  r_mask;

    logic [SLOT_W-1:0] r_head;
    logic [SLOT_W-1:0] r_tail;
    logic              r_tail_wrap;
    logic [CNT_W-1:0]  r_live;
    logic [SLOT_W-1:0] r_clr_cnt;

    logic              r_ok;
    logic [IDX_W-1:0]  r_new_index;
    logic [GIN_W-1:0]  r_new_gen;
    logic [MSK_W-1:0]  r_sig_out;

    logic [GEN_W-1:0]  s_gen;
    logic [SIG_W-1:0]  s_sig;
    logic [GEN_W-1:0]  inc_gen;
    logic [SIG_W-1:0]  bit_sel;
    logic [SIG_W-1:0]  mask;
    logic              in_bounds;
    logic              handle_ok;
    logic              bit_ok;
    logic              fifo_hit;

    logic              n_ok;
    logic [IDX_W-1:0]  n_new_index;
    logic [GIN_W-1:0]  n_new_gen;
    logic [MSK_W-1:0]  n_sig_out;
    logic              slot_we;
    logic [ENT_W-1:0]  slot_wdata;
    logic              fifo_push;
    logic              fifo_pop;
    logic [FIFO_W-1:0] fifo_wdata;

    assign o_status.clr_last = (r_clr_cnt == LAST_SLOT);

    // request capture and synchronous memory reads
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func    <= i_func;
            r_slot    <= i_slot_index;
            r_gen     <= i_generation_in;
            r_bit     <= i_bit_index;
            r_mask    <= i_bit_mask;
            r_slot_rd <= r_slot_mem[i_slot_index[SLOT_W-1:0]];
            r_fifo_rd <= r_fifo_mem[r_head];
        end
    end

    always_comb begin
        s_gen     = r_slot_rd[ENT_W-1:SIG_W];
        s_sig     = r_slot_rd[SIG_W-1:0];
        inc_gen   = s_gen + GEN_ONE;
        in_bounds = (32'(r_slot) < 32'(MAX_SLOTS));
        handle_ok = in_bounds && (s_gen == GEN_W'(r_gen));
        bit_ok    = (32'(r_bit) < 32'(SIG_W));
        bit_sel   = bit_ok ? (SIG_W'(1) << r_bit) : '0;
        mask      = SIG_W'(r_mask);
        // fifo positions the tail has not yet written stand for slot r_head, gen 1
        fifo_hit  = r_tail_wrap || (r_head < r_tail);

        n_ok        = 1'b0;
        n_new_index = '0;
        n_new_gen   = '0;
        n_sig_out   = '0;
        slot_we     = 1'b0;
        slot_wdata  = r_slot_rd;
        fifo_push   = 1'b0;
        fifo_pop    = 1'b0;
        fifo_wdata  = {r_slot[SLOT_W-1:0], inc_gen};

        unique case (r_func)
            gha_pkg::F_CREATE: begin
                if (r_live < FULL_COUNT) begin
                    n_ok     = 1'b1;
                    fifo_pop = 1'b1;
                    if (fifo_hit) begin
                        n_new_index = IDX_W'(r_fifo_rd[FIFO_W-1:GEN_W]);
                        n_new_gen   = GIN_W'(r_fifo_rd[GEN_W-1:0]);
                    end else begin
                        n_new_index = IDX_W'(r_head);
                        n_new_gen   = GIN_W'(GEN_ONE);
                    end
                end
            end
            gha_pkg::F_FREE: begin
                if ((r_live != '0) && in_bounds) begin
                    n_ok       = 1'b1;
                    fifo_push  = 1'b1;
                    slot_we    = 1'b1;
                    slot_wdata = {inc_gen, s_sig};
                end
            end
            gha_pkg::F_SET_BIT: begin
                if (handle_ok && bit_ok && ((s_sig & bit_sel) == '0)) begin
                    n_ok       = 1'b1;
                    slot_we    = 1'b1;
                    slot_wdata = {s_gen, s_sig | bit_sel};
                end
            end
            gha_pkg::F_CLR_BIT: begin
                if (handle_ok && bit_ok && ((s_sig & bit_sel) != '0)) begin
                    n_ok       = 1'b1;
                    slot_we    = 1'b1;
                    slot_wdata = {s_gen, s_sig & ~bit_sel};
                end
            end
            gha_pkg::F_SET_MASK: begin
                if (handle_ok) begin
                    n_ok       = ((s_sig & mask) == '0);
                    slot_we    = 1'b1;
                    slot_wdata = {s_gen, s_sig | mask};
                end
            end
            gha_pkg::F_CLR_MASK: begin
                if (handle_ok) begin
                    n_ok       = ((~s_sig & mask) == '0);
                    slot_we    = 1'b1;
                    slot_wdata = {s_gen, s_sig & ~mask};
                end
            end
            gha_pkg::F_TEST_BIT: begin
                n_ok = handle_ok && bit_ok && ((s_sig & bit_sel) != '0);
            end
            gha_pkg::F_READ_SIG: begin
                if (handle_ok) begin
                    n_ok      = 1'b1;
                    n_sig_out = MSK_W'(s_sig);
                end
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    // memory writes: clearing pass after reset, else the executing request
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_step) begin
            r_slot_mem[r_clr_cnt] <= {GEN_ONE, {SIG_W{1'b0}}};
        end else if (i_cmd.exec && slot_we) begin
            r_slot_mem[r_slot[SLOT_W-1:0]] <= slot_wdata;
        end
        if (i_cmd.exec && fifo_push) begin
            r_fifo_mem[r_tail] <= fifo_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head      <= '0;
            r_tail      <= '0;
            r_tail_wrap <= 1'b0;
            r_live      <= '0;
            r_clr_cnt   <= '0;
        end else begin
            if (i_cmd.clr_step && (r_clr_cnt != LAST_SLOT)) begin
                r_clr_cnt <= r_clr_cnt + SLOT_W'(1);
            end
            if (i_cmd.exec && fifo_pop) begin
                r_head <= (r_head == LAST_SLOT) ? '0 : r_head + SLOT_W'(1);
                r_live <= r_live + CNT_W'(1);
            end
            if (i_cmd.exec && fifo_push) begin
                r_tail <= (r_tail == LAST_SLOT) ? '0 : r_tail + SLOT_W'(1);
                if (r_tail == LAST_SLOT) begin
                    r_tail_wrap <= 1'b1;
                end
                r_live <= r_live - CNT_W'(1);
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_ok        <= n_ok;
            r_new_index <= n_new_index;
            r_new_gen   <= n_new_gen;
            r_sig_out   <= n_sig_out;
        end
    end

    assign o_ok             = r_ok;
    assign o_new_index      = r_new_index;
    assign o_new_generation = r_new_gen;
    assign o_signature_out  = r_sig_out;

endmodule

`default_nettype wire

### sv/generational_handle_allocator_top.sv
// a request is captured on acceptance, executed in S_EXEC, then its result is registered and valid
// requests do not overlap: s_tready is low in S_EXEC, set by the read then write of the slot memory
// the result register frees as the result is taken, so a new request enters that cycle
// reset: synchronous active low; then a clearing pass sets every
// slot to generation 1 and an empty signature, with s_tready low throughout
`default_nettype none

module generational_handle_allocator_top #(
    parameter int MAX_SLOTS       = 1024,
    parameter int SIGNATURE_BITS  = 64,
    parameter int GENERATION_BITS = 16
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // slot_index[9:0], generation_in[25:10], bit_index[31:26], bit_mask[95:32]
    input  wire logic [gha_pkg::S_TDATA_W-1:0]     i_s_tdata,
    // func[2:0]
    input  wire logic [gha_pkg::FUNC_W-1:0]        i_s_tuser,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // new_index[9:0], new_generation[25:10], signature_out[89:26], zero pad
    output logic [gha_pkg::M_TDATA_W-1:0]          o_m_tdata,
    // ok[0]
    output logic                                   o_m_tuser
);

    localparam int IDX_W = gha_pkg::INDEX_W;
    localparam int GIN_W = gha_pkg::GEN_IN_W;
    localparam int BIT_W = gha_pkg::BIT_W;
    localparam int MSK_W = gha_pkg::MASK_W;
    localparam int PAD_W = gha_pkg::M_PAD_W;

    gha_pkg::t_cmd    cmd;
    gha_pkg::t_status status;

    logic [IDX_W-1:0] new_index;
    logic [GIN_W-1:0] new_generation;
    logic [MSK_W-1:0] signature_out;

    gha_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    gha_datapath #(
        .MAX_SLOTS       (MAX_SLOTS),
        .SIGNATURE_BITS  (SIGNATURE_BITS),
        .GENERATION_BITS (GENERATION_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd            (cmd),
        .o_status         (status),
        .i_func           (gha_pkg::t_func'(i_s_tuser)),
        .i_slot_index     (i_s_tdata[IDX_W-1:0]),
        .i_generation_in  (i_s_tdata[IDX_W+GIN_W-1:IDX_W]),
        .i_bit_index      (i_s_tdata[IDX_W+GIN_W+BIT_W-1:IDX_W+GIN_W]),
        .i_bit_mask       (i_s_tdata[IDX_W+GIN_W+BIT_W+MSK_W-1:IDX_W+GIN_W+BIT_W]),
        .o_ok             (o_m_tuser),
        .o_new_index      (new_index),
        .o_new_generation (new_generation),
        .o_signature_out  (signature_out)
    );

    assign o_m_tdata = {{PAD_W{1'b0}}, signature_out, new_generation, new_index};

endmodule

`default_nettype wire
